FILE: rtl/stbe_pkg.sv
// Shared types, status codes and widths for the sorted triple bitmap encoder.
package stbe_pkg;

    localparam int ID_BITS    = 32;
    localparam int FIELD_BITS = 32;
    localparam int ID_W       = (ID_BITS < FIELD_BITS) ? ID_BITS : FIELD_BITS;

    localparam logic ACT_TRIPLE = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_SKIP  = 3'd1;
    localparam logic [2:0] ST_SUBJ_GAP   = 3'd2;
    localparam logic [2:0] ST_PRED_DECR  = 3'd3;
    localparam logic [2:0] ST_OBJ_ORDER  = 3'd4;
    localparam logic [2:0] ST_HALTED     = 3'd5;

    typedef struct packed {
        logic                  action;
        logic [FIELD_BITS-1:0] subject_id;
        logic [FIELD_BITS-1:0] predicate_id;
        logic [FIELD_BITS-1:0] object_id;
    } req_t;

    typedef struct packed {
        logic                  ybit_valid;
        logic                  ybit;
        logic                  yval_valid;
        logic [FIELD_BITS-1:0] yval;
        logic                  zbit_valid;
        logic                  zbit;
        logic                  zval_valid;
        logic [FIELD_BITS-1:0] zval;
        logic [2:0]            status;
    } res_t;

endpackage

FILE: rtl/sorted_triple_bitmap_encoder.sv
// Top level of the sorted triple bitmap encoder: request register, check logic, result register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+--------------------------------------
//   request | req_valid | req_stall | req_data (action, subject/pred/object)
//   result  | res_valid | res_stall | res_data (bitmap bits, values, status)
//
// Each request yields exactly one result; it passes through the request register and then the result register.
// One request is taken every cycle while the result side does not stall.
// The compare against the previous triple sits between the request and result registers.
// Reset clears the stored triple, the seen flag and the halt flag.
// A result stall holds the result register and backs up into req_stall.
module sorted_triple_bitmap_encoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stbe_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_stall,
    output stbe_pkg::res_t res_data
);
    import stbe_pkg::*;

    logic            s1_valid_reg;
    req_t            s1_data_reg;
    logic            res_valid_reg;
    res_t            res_data_reg;
    res_t            res_data_next;
    logic [ID_W-1:0] prev_subject_reg;
    logic [ID_W-1:0] prev_predicate_reg;
    logic [ID_W-1:0] prev_object_reg;
    logic            seen_any_reg;
    logic            halted_reg;

    logic            advance;
    logic            upd;
    logic            halt_set;
    logic [ID_W-1:0] x;
    logic [ID_W-1:0] y;
    logic [ID_W-1:0] z;
    logic [ID_W-1:0] subj_succ;

    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign x         = s1_data_reg.subject_id[ID_W-1:0];
    assign y         = s1_data_reg.predicate_id[ID_W-1:0];
    assign z         = s1_data_reg.object_id[ID_W-1:0];
    assign subj_succ = prev_subject_reg + ID_W'(1);

    always_comb
    begin
        res_data_next = '0;
        upd           = 1'b0;
        halt_set      = 1'b0;
        res_data_next.status = ST_OK;
        if (halted_reg)
        begin
            res_data_next.status = ST_HALTED;
        end
        else if (s1_data_reg.action == ACT_FINISH)
        begin
            // append closing bits only when a triple went through
            res_data_next.ybit_valid = seen_any_reg;
            res_data_next.ybit       = seen_any_reg;
            res_data_next.zbit_valid = seen_any_reg;
            res_data_next.zbit       = seen_any_reg;
            halt_set                 = 1'b1;
        end
        else if (x == '0 || y == '0 || z == '0)
        begin
            res_data_next.status = ST_ZERO_SKIP;
        end
        else if (!seen_any_reg)
        begin
            res_data_next.yval_valid = 1'b1;
            res_data_next.yval       = FIELD_BITS'(y);
            res_data_next.zval_valid = 1'b1;
            res_data_next.zval       = FIELD_BITS'(z);
            upd                      = 1'b1;
        end
        else if (x != prev_subject_reg)
        begin
            if (x != subj_succ)
            begin
                res_data_next.status = ST_SUBJ_GAP;
                halt_set             = 1'b1;
            end
            else
            begin
                res_data_next.ybit_valid = 1'b1;
                res_data_next.ybit       = 1'b1;
                res_data_next.yval_valid = 1'b1;
                res_data_next.yval       = FIELD_BITS'(y);
                res_data_next.zbit_valid = 1'b1;
                res_data_next.zbit       = 1'b1;
                res_data_next.zval_valid = 1'b1;
                res_data_next.zval       = FIELD_BITS'(z);
                upd                      = 1'b1;
            end
        end
        else if (y != prev_predicate_reg)
        begin
            if (y < prev_predicate_reg)
            begin
                res_data_next.status = ST_PRED_DECR;
                halt_set             = 1'b1;
            end
            else
            begin
                res_data_next.ybit_valid = 1'b1;
                res_data_next.yval_valid = 1'b1;
                res_data_next.yval       = FIELD_BITS'(y);
                res_data_next.zbit_valid = 1'b1;
                res_data_next.zbit       = 1'b1;
                res_data_next.zval_valid = 1'b1;
                res_data_next.zval       = FIELD_BITS'(z);
                upd                      = 1'b1;
            end
        end
        else if (z <= prev_object_reg)
        begin
            res_data_next.status = ST_OBJ_ORDER;
            halt_set             = 1'b1;
        end
        else
        begin
            res_data_next.zbit_valid = 1'b1;
            res_data_next.zval_valid = 1'b1;
            res_data_next.zval       = FIELD_BITS'(z);
            upd                      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            res_valid_reg      <= 1'b0;
            prev_subject_reg   <= '0;
            prev_predicate_reg <= '0;
            prev_object_reg    <= '0;
            seen_any_reg       <= 1'b0;
            halted_reg         <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                s1_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (advance && upd)
            begin
                prev_subject_reg   <= x;
                prev_predicate_reg <= y;
                prev_object_reg    <= z;
                seen_any_reg       <= 1'b1;
            end
            if (advance && halt_set)
            begin
                halted_reg <= 1'b1;
            end
        end
    end

    // payload registers: load on request accept / advance
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_data_reg <= req_data;
        end
        if (advance)
        begin
            res_data_reg <= res_data_next;
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag dropped without reset");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_data_next.status == ST_SUBJ_GAP
                     || res_data_next.status == ST_PRED_DECR
                     || res_data_next.status == ST_OBJ_ORDER)) |=> halted_reg)
        else $error("order error did not halt the encoder");

    a_halted_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && halted_reg) |=> (res_data_reg.status == ST_HALTED
                                     && !res_data_reg.yval_valid
                                     && !res_data_reg.zval_valid))
        else $error("halted encoder produced appends");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && res_valid_reg && res_stall))
        else $error("request stalled without a blocked result");

    a_seen_before_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !seen_any_reg) |-> (!res_data_next.ybit_valid
                                        && !res_data_next.zbit_valid))
        else $error("bitmap bit before the first triple");

endmodule

FILE: verif/sorted_triple_bitmap_encoder_tb.sv
// Self-checking testbench for the sorted triple bitmap encoder.
`timescale 1ns / 100ps

module sorted_triple_bitmap_encoder_tb;
    import stbe_pkg::*;

    localparam int          IDLE_PCT       = 23;
    localparam int          HOLDOFF_CYCLES = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          MAX_REPORTS    = 40;
    localparam logic [31:0] FIRST_SUBJECT  = 32'h7FFF_FFF0;
    localparam logic [31:0] ID_MAX         = 32'hFFFF_FFFF;

    typedef enum int unsigned {
        END_FINISH,
        END_SUBJ_GAP,
        END_PRED_DECR,
        END_OBJ_ORDER
    } stream_end_e;

    logic clk;
    logic rst_n;
    logic req_valid = 1'b0;
    req_t req_data  = '0;
    logic res_stall = 1'b0;
    logic req_stall;
    logic res_valid;
    res_t res_data;

    // Last well-formed triple sent, used to build the next one in order.
    logic [31:0] stream_subj = '0;
    logic [31:0] stream_pred = '0;
    logic [31:0] stream_obj  = '0;

    // Encoder state as predicted from the accepted requests.
    logic [ID_W-1:0] enc_subj   = '0;
    logic [ID_W-1:0] enc_pred   = '0;
    logic [ID_W-1:0] enc_obj    = '0;
    logic            enc_seen   = 1'b0;
    logic            enc_halted = 1'b0;

    res_t bitmap_expect_q[$];
    int   mismatch_count = 0;
    int   stuck_cycles   = 0;
    bit   no_idle        = 1'b0;
    int   holdoff_reqs   = 0;
    int   holdoff_served = 0;
    int   holdoff_left   = 0;

    sorted_triple_bitmap_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic res_t encode_triple(input req_t r);
        res_t            e;
        logic [ID_W-1:0] s;
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] o;
        logic [ID_W-1:0] succ;
        e      = '0;
        e.status = ST_OK;
        s      = r.subject_id[ID_W-1:0];
        p      = r.predicate_id[ID_W-1:0];
        o      = r.object_id[ID_W-1:0];
        succ   = enc_subj + 1'b1;
        if (enc_halted)
            e.status = ST_HALTED;
        else if (r.action == ACT_FINISH)
        begin
            if (enc_seen)
            begin
                e.ybit_valid = 1'b1;
                e.ybit       = 1'b1;
                e.zbit_valid = 1'b1;
                e.zbit       = 1'b1;
            end
            enc_halted = 1'b1;
        end
        else if (s == '0 || p == '0 || o == '0)
            e.status = ST_ZERO_SKIP;
        else
        begin
            if (!enc_seen)
            begin
                e.yval_valid = 1'b1;
                e.yval       = p;
                e.zval_valid = 1'b1;
                e.zval       = o;
            end
            else if (s != enc_subj)
            begin
                if (s != succ)
                    e.status = ST_SUBJ_GAP;
                else
                begin
                    e.ybit_valid = 1'b1;
                    e.ybit       = 1'b1;
                    e.yval_valid = 1'b1;
                    e.yval       = p;
                    e.zbit_valid = 1'b1;
                    e.zbit       = 1'b1;
                    e.zval_valid = 1'b1;
                    e.zval       = o;
                end
            end
            else if (p != enc_pred)
            begin
                if (p < enc_pred)
                    e.status = ST_PRED_DECR;
                else
                begin
                    e.ybit_valid = 1'b1;
                    e.yval_valid = 1'b1;
                    e.yval       = p;
                    e.zbit_valid = 1'b1;
                    e.zbit       = 1'b1;
                    e.zval_valid = 1'b1;
                    e.zval       = o;
                end
            end
            else if (o <= enc_obj)
                e.status = ST_OBJ_ORDER;
            else
            begin
                e.zbit_valid = 1'b1;
                e.zval_valid = 1'b1;
                e.zval       = o;
            end
            // An order error halts and keeps the previous triple.
            if (e.status == ST_OK)
            begin
                enc_subj = s;
                enc_pred = p;
                enc_obj  = o;
                enc_seen = 1'b1;
            end
            else
                enc_halted = 1'b1;
        end
        return e;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (bitmap_expect_q.size() == 0)
        begin
            report_mismatch("result with no request pending");
            return;
        end
        want = bitmap_expect_q.pop_front();
        check_field("ybit_valid", 32'(got.ybit_valid), 32'(want.ybit_valid));
        check_field("ybit", 32'(got.ybit), 32'(want.ybit));
        check_field("yval_valid", 32'(got.yval_valid), 32'(want.yval_valid));
        check_field("yval", got.yval, want.yval);
        check_field("zbit_valid", 32'(got.zbit_valid), 32'(want.zbit_valid));
        check_field("zbit", 32'(got.zbit), 32'(want.zbit));
        check_field("zval_valid", 32'(got.zval_valid), 32'(want.zval_valid));
        check_field("zval", got.zval, want.zval);
        check_field("status", 32'(got.status), 32'(want.status));
    endtask

    // Check results before queueing the request taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                check_result(res_data);
            if (req_valid && !req_stall)
                bitmap_expect_q = {bitmap_expect_q, encode_triple(req_data)};
        end
    end

    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            res_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else if (holdoff_served != holdoff_reqs)
        begin
            holdoff_served <= holdoff_served + 1;
            holdoff_left   <= HOLDOFF_CYCLES;
            res_stall      <= 1'b1;
        end
        else
            res_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_req(input req_t r);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    function automatic req_t pack_triple(input logic [31:0] s, input logic [31:0] p,
                                         input logic [31:0] o);
        req_t r;
        r.action       = ACT_TRIPLE;
        r.subject_id   = s;
        r.predicate_id = p;
        r.object_id    = o;
        return r;
    endfunction

    // Send a triple and advance the stream position if it is a real triple.
    task automatic send_triple(input logic [31:0] s, input logic [31:0] p,
                               input logic [31:0] o);
        if (s != '0 && p != '0 && o != '0)
        begin
            stream_subj = s;
            stream_pred = p;
            stream_obj  = o;
        end
        send_req(pack_triple(s, p, o));
    endtask

    function automatic logic [31:0] rand_id();
        logic [31:0] v;
        if ($urandom_range(3) == 0)
        begin
            v = $urandom;
            if (v == '0)
                v = 32'd1;
        end
        else
            v = $urandom_range(1, 40);
        return v;
    endfunction

    // Pick a value strictly above base; base must be below the maximum ID.
    function automatic logic [31:0] rand_above(input logic [31:0] base);
        logic [31:0] room;
        logic [31:0] step;
        room = ID_MAX - base;
        if ($urandom_range(9) == 0)
            step = ($urandom % room) + 1;
        else
            step = $urandom_range(1, (room < 16) ? room : 16);
        return base + step;
    endfunction

    task automatic send_random_item();
        req_t        r;
        int unsigned pick;
        int unsigned zmask;
        logic [31:0] s;
        logic [31:0] p;
        logic [31:0] o;
        if ($urandom_range(99) < 6)
        begin
            r     = pack_triple($urandom, $urandom, $urandom);
            zmask = $urandom_range(1, 7);
            if (zmask[0])
                r.subject_id = '0;
            if (zmask[1])
                r.predicate_id = '0;
            if (zmask[2])
                r.object_id = '0;
            send_req(r);
        end
        else
        begin
            pick = $urandom_range(99);
            // Fall back to a wider step when the current group cannot grow.
            if (pick >= 45 && stream_obj == ID_MAX)
                pick = 30;
            if (pick >= 15 && pick < 45 && stream_pred == ID_MAX)
                pick = (stream_obj == ID_MAX) ? 0 : 60;
            s = stream_subj;
            p = stream_pred;
            if (pick < 15)
            begin
                s = stream_subj + 1;
                p = rand_id();
                o = rand_id();
            end
            else if (pick < 45)
            begin
                p = rand_above(stream_pred);
                o = rand_id();
            end
            else
                o = rand_above(stream_obj);
            send_triple(s, p, o);
        end
    endtask

    task automatic test_directed_stream();
        // Zero components before any triple must leave the stream unstarted.
        send_triple('0, '0, '0);
        send_triple('0, ID_MAX, ID_MAX);
        send_triple(FIRST_SUBJECT, 1, 1);
        send_triple(FIRST_SUBJECT, 1, 2);
        send_triple(FIRST_SUBJECT, 1, ID_MAX);
        send_triple(FIRST_SUBJECT, 2, 1);
        send_triple(FIRST_SUBJECT, ID_MAX, 1);
        send_triple(FIRST_SUBJECT, ID_MAX, ID_MAX);
        send_triple(ID_MAX, ID_MAX, '0);
        send_triple(ID_MAX, '0, ID_MAX);
        send_triple('0, ID_MAX, ID_MAX);
        send_triple(FIRST_SUBJECT + 1, ID_MAX, 5);
        send_triple(FIRST_SUBJECT + 1, ID_MAX, 6);
        send_triple(FIRST_SUBJECT + 2, 1, ID_MAX);
        send_triple(FIRST_SUBJECT + 2, 2, 1);
        send_triple(FIRST_SUBJECT + 3, 32'h8000_0000, 32'h5555_5555);
        send_triple(FIRST_SUBJECT + 3, 32'h8000_0000, 32'hAAAA_AAAA);
    endtask

    task automatic test_random_stream(input int n_items);
        repeat (n_items)
            send_random_item();
    endtask

    task automatic test_backpressure(input int n_items);
        holdoff_reqs++;
        repeat (n_items)
            send_random_item();
    endtask

    task automatic test_no_idle_stream(input int n_items);
        no_idle = 1'b1;
        repeat (n_items)
            send_random_item();
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (bitmap_expect_q.size() != 0);
    endtask

    task automatic test_halt_and_after(input int n_after);
        req_t        r;
        stream_end_e ending;
        ending = stream_end_e'($urandom_range(3));
        unique case (ending)
            END_FINISH:
            begin
                r        = pack_triple($urandom, $urandom, $urandom);
                r.action = ACT_FINISH;
            end
            END_SUBJ_GAP:
                r = pack_triple(stream_subj + 2 + $urandom_range(1000),
                                rand_id(), rand_id());
            END_PRED_DECR:
            begin
                send_triple(stream_subj + 1, 100, 100);
                r = pack_triple(stream_subj, $urandom_range(1, 99), rand_id());
            end
            END_OBJ_ORDER:
            begin
                send_triple(stream_subj + 1, 100, 100);
                r = pack_triple(stream_subj, 100, $urandom_range(1, 100));
            end
        endcase
        send_req(r);
        // Every request from here on must be answered as halted.
        repeat (n_after)
        begin
            r        = pack_triple($urandom, $urandom, $urandom);
            r.action = ($urandom_range(1) != 0) ? ACT_FINISH : ACT_TRIPLE;
            send_req(r);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_stream();
        test_random_stream(720);
        test_backpressure(60);
        test_drain_pause();
        test_no_idle_stream(300);
        test_random_stream(820);
        test_halt_and_after(30);
        test_drain_pause();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
